@@ design/kmer_neighbor_graph_builder_assert.svh @@
// Assertion macros shared by the kmer neighbor graph builder RTL.
`ifndef KMER_NEIGHBOR_GRAPH_BUILDER_ASSERT_SVH
`define KMER_NEIGHBOR_GRAPH_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KNGB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kngb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KNGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kngb: next-cycle check failed");

`endif

@@ design/kngb_pkg.sv @@
// Package with widths, types and constants of the kmer neighbor graph builder.
`timescale 1ns / 1ps
`default_nettype none
package kngb_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int MAX_KMER      = 8;
  localparam int CHAR_W        = 8;
  localparam int IDX_W         = $clog2(MAX_VERTICES);
  localparam int CNT_W         = $clog2(MAX_VERTICES + 1);
  localparam int MLEN_W        = 4;
  localparam int WIN_W         = 8;
  localparam int WINDOW_FACTOR = 10;

  typedef logic [MAX_KMER*CHAR_W-1:0] kmer_t;
  typedef logic [7:0]                 seq_t;
  typedef logic [15:0]                pos_t;
  typedef logic [MLEN_W-1:0]          mlen_t;
  typedef logic [IDX_W-1:0]           vidx_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [MAX_VERTICES-1:0]    vmask_t;

  typedef struct packed {
    seq_t  seq;
    pos_t  pos;
    kmer_t kmer;
  } entry_t;

endpackage
`default_nettype wire

@@ design/kngb_if.sv @@
// Handshake interfaces for vertex input and neighbor result channels.
`timescale 1ns / 1ps
`default_nettype none
interface kngb_vertex_if;
  import kngb_pkg::*;

  logic  valid;
  logic  ready;
  logic  first_of_set;
  seq_t  sequence_number;
  pos_t  position;
  kmer_t kmer_chars;

  modport source (output valid, first_of_set, sequence_number, position, kmer_chars,
                  input ready);
  modport sink   (input valid, first_of_set, sequence_number, position, kmer_chars,
                  output ready);
endinterface

interface kngb_result_if;
  import kngb_pkg::*;

  logic   valid;
  logic   ready;
  vidx_t  vertex_index;
  vmask_t neighbor_mask;
  logic   store_full;

  modport source (output valid, vertex_index, neighbor_mask, store_full, input ready);
  modport sink   (input valid, vertex_index, neighbor_mask, store_full, output ready);
endinterface
`default_nettype wire

@@ design/kmer_neighbor_graph_builder.sv @@
// Flow: a vertex is taken while idle, and the stored vertices ahead of it are read and compared
//   in turn; its result is published once the result register is free, and the next vertex is taken after that.
// Throughput is set by the vertex store, a single-port memory read one row per cycle
//   and scanned through one shared compare unit.
// Reset (rst, synchronous): empty store, motif_length back to 8, no result pending.
//   Store rows are not cleared; only rows below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module kmer_neighbor_graph_builder (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wr_en,
  input  wire kngb_pkg::mlen_t cfg_wr_data,
  kngb_vertex_if.sink          vertex,
  kngb_result_if.source        result
);
  import kngb_pkg::*;

  `include "kmer_neighbor_graph_builder_assert.svh"

  // Sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;
  mlen_t      motif_length;
  cnt_t       fill_count;

  // Vertex under work, held for the whole scan
  seq_t   cur_seq;
  pos_t   cur_pos;
  kmer_t  cur_kmer;
  vmask_t mask;

  // Scan pointer and the compare stage that trails it by one register
  cnt_t   scan_idx;
  logic   cmp_valid;
  vidx_t  cmp_idx;
  entry_t rd_data;

  // Vertex store
  entry_t store [MAX_VERTICES];

  // Result register
  logic   out_valid;
  vidx_t  out_index;
  vmask_t out_mask;
  logic   out_full;

  logic   in_xfer;
  logic   rd_en;
  logic   scan_done;
  logic   store_has_room;
  logic   out_free;

  assign in_xfer        = vertex.valid && vertex.ready;
  assign scan_done      = (scan_idx >= fill_count);
  assign rd_en          = (state == ST_SCAN) && !scan_done;
  assign store_has_room = (fill_count < cnt_t'(MAX_VERTICES));
  assign out_free       = !out_valid || result.ready;

  // Take a new vertex only while idle; a pending result lives in its own register.
  assign vertex.ready = (state == ST_IDLE);

  assign result.valid         = out_valid;
  assign result.vertex_index  = out_index;
  assign result.neighbor_mask = out_mask;
  assign result.store_full    = out_full;

  // ---------------------------------------------------------------------------
  // Shared compare unit: one stored row against the current vertex per cycle.
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]    window;
  pos_t                pos_gap;
  logic [MAX_KMER-1:0] miss;
  logic                seq_differs;
  logic                in_window;
  logic                close_chars;
  logic                hit;

  // Window is 10 * motif_length, built as 8x + 2x.
  assign window = (WIN_W'(motif_length) << 3) + (WIN_W'(motif_length) << 1);

  always_comb begin
    for (int i = 0; i < MAX_KMER; i++) begin
      // Compare character i only when it lies inside the motif.
      miss[i] = (cur_kmer[i*CHAR_W +: CHAR_W] != rd_data.kmer[i*CHAR_W +: CHAR_W]) &&
                (MLEN_W'(i) < motif_length);
    end
  end

  assign pos_gap     = (cur_pos >= rd_data.pos) ? (cur_pos - rd_data.pos)
                                                : (rd_data.pos - cur_pos);
  assign seq_differs = (rd_data.seq != cur_seq);
  assign in_window   = (pos_gap < pos_t'(window));
  // At most one mismatching character: clearing the lowest set bit leaves nothing.
  assign close_chars = ((miss & (miss - MAX_KMER'(1))) == '0);
  assign hit         = seq_differs && in_window && close_chars;

  // ---------------------------------------------------------------------------
  // Store: registered read during the scan, one write when the vertex is kept.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[scan_idx[IDX_W-1:0]];
    end
    if (state == ST_WRITE && out_free && store_has_room) begin
      store[fill_count[IDX_W-1:0]] <= '{seq: cur_seq, pos: cur_pos, kmer: cur_kmer};
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      motif_length <= mlen_t'(MAX_KMER);
    end else if (cfg_wr_en) begin
      motif_length <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      scan_idx   <= '0;
      cmp_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Publish a new result when the register frees up; otherwise drop the
      // current one once the sink takes it.
      if (state == ST_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            // Empty the store ahead of the first vertex of a set.
            if (vertex.first_of_set) begin
              fill_count <= '0;
            end
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Advance the read pointer; the compare stage works on each row in the cycle after its read.
          cmp_valid <= rd_en;
          if (rd_en) begin
            scan_idx <= scan_idx + cnt_t'(1);
          end else begin
            // The last compare lands in the mask at this same edge.
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          cmp_valid <= 1'b0;
          // Hold until the result register is free, then publish, and store if room remains.
          if (out_free) begin
            if (store_has_room) begin
              fill_count <= fill_count + cnt_t'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state     <= ST_IDLE;
          cmp_valid <= 1'b0;
        end
      endcase
    end
  end

  // Payload registers: vertex capture, mask build-up and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_seq  <= vertex.sequence_number;
      cur_pos  <= vertex.position;
      cur_kmer <= vertex.kmer_chars;
      mask     <= '0;
    end else if (cmp_valid && hit) begin
      mask[cmp_idx] <= 1'b1;
    end
    if (rd_en) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    if (state == ST_WRITE && out_free) begin
      out_mask  <= mask;
      out_index <= store_has_room ? fill_count[IDX_W-1:0] : '0;
      out_full  <= !store_has_room;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `KNGB_ASSERT_NEXT(a_busy_after_xfer, clk, rst, in_xfer, !vertex.ready)
  `KNGB_ASSERT_SAME(a_fill_bounded, clk, rst, 1'b1, fill_count <= cnt_t'(MAX_VERTICES))
  `KNGB_ASSERT_SAME(a_cmp_in_scan, clk, rst, cmp_valid, state == ST_SCAN || state == ST_WRITE)
  `KNGB_ASSERT_SAME(a_scan_complete, clk, rst, state == ST_WRITE, scan_idx == fill_count)
  `KNGB_ASSERT_SAME(a_mask_below_slot, clk, rst, out_valid && !out_full,
                    (out_mask >> out_index) == '0)

endmodule
`default_nettype wire
